[hdl/p1_telegram_crc_checker_core_assert.svh]
// assertion macros for the p1 telegram crc checker
`ifndef P1_TELEGRAM_CRC_CHECKER_CORE_ASSERT_SVH
`define P1_TELEGRAM_CRC_CHECKER_CORE_ASSERT_SVH

// property checked at every rising clk edge outside reset
`define P1CRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising clk edge, reset included
`define P1CRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/p1crc_pkg.sv]
// types, byte codes and crc functions for the p1 telegram crc checker
`timescale 1ns / 1ps

package p1crc_pkg;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  BYTE_SLASH = 8'h2F;
  localparam logic [7:0]  BYTE_BANG  = 8'h21;
  localparam logic [7:0]  BYTE_LF    = 8'h0A;
  localparam logic [2:0]  DIGITS_PER_CRC = 3'd4;

  typedef enum logic [1:0] {
    PH_ACCUM  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_SKIP   = 2'd2
  } p1crc_phase_t;

  typedef struct packed {
    p1crc_phase_t phase;
    logic [15:0]  crc;
    logic [2:0]   cnt;
    logic [15:0]  rcv;
  } p1crc_state_t;

  typedef struct packed {
    logic        hit;
    logic        ok;
    logic [15:0] computed;
    logic [15:0] received;
  } p1crc_result_t;

  // one byte folded into a reflected crc-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[hdl/p1crc_step.sv]
// per-byte parser step: next parse state and the result for one byte
`timescale 1ns / 1ps

module p1crc_step import p1crc_pkg::*; (
  input  p1crc_state_t  cur,
  input  logic [7:0]    data_byte,
  output p1crc_state_t  nxt,
  output p1crc_result_t res
);

  logic [4:0]  hex;
  logic [15:0] rcv_shift;
  logic [2:0]  cnt_inc;
  logic        last_digit;
  logic [15:0] crc_base;

  assign hex        = hex_decode(data_byte);
  assign rcv_shift  = {cur.rcv[11:0], hex[3:0]};
  assign cnt_inc    = cur.cnt + 3'd1;
  assign last_digit = (cnt_inc >= DIGITS_PER_CRC);
  assign crc_base   = (data_byte == BYTE_SLASH) ? 16'h0000 : cur.crc;

  // next state
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_DIGITS: begin
        if (hex[4]) begin
          nxt.rcv = rcv_shift;
          nxt.cnt = cnt_inc;
          if (last_digit) begin
            nxt.crc   = 16'h0000;
            nxt.phase = PH_SKIP;
          end
        end else begin
          nxt.crc   = 16'h0000;
          nxt.phase = (data_byte == BYTE_LF) ? PH_ACCUM : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (data_byte == BYTE_LF) begin
          nxt.phase = PH_ACCUM;
        end
      end
      default: begin
        nxt.phase = PH_ACCUM;
        nxt.crc   = crc_fold(crc_base, data_byte);
        if (data_byte == BYTE_BANG) begin
          nxt.phase = PH_DIGITS;
          nxt.cnt   = 3'd0;
          nxt.rcv   = 16'h0000;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res.hit      = 1'b0;
    res.ok       = 1'b0;
    res.computed = cur.crc;
    res.received = cur.rcv;
    unique case (cur.phase)
      PH_DIGITS: begin
        if (hex[4]) begin
          res.hit      = last_digit;
          res.ok       = (rcv_shift == cur.crc);
          res.received = rcv_shift;
        end else begin
          res.hit = 1'b1;
        end
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

[hdl/p1_telegram_crc_checker_core.sv]
// an accepted byte waits in the input register; its result, if any, then goes to the output register
// throughput: one byte per cycle while no output item is stalled; the crc fold and parser step are combinational
// in_stall rises only while the input register holds a byte and the output item is stalled
// reset (rst, synchronous): crc and digit state cleared, parser in accumulate, no item held
`timescale 1ns / 1ps

`include "p1_telegram_crc_checker_core_assert.svh"

module p1_telegram_crc_checker_core import p1crc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        crc_valid,
  output logic [15:0] computed_crc,
  output logic [15:0] received_crc
);

  logic          byte_valid;
  logic [7:0]    byte_q;
  p1crc_state_t  st;
  p1crc_state_t  st_next;
  p1crc_result_t res;
  logic          proc_fire;

  assign proc_fire = byte_valid && (!out_valid || !out_stall);
  assign in_stall  = byte_valid && !proc_fire;

  p1crc_step u_step (
    .cur       (st),
    .data_byte (byte_q),
    .nxt       (st_next),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_ACCUM;
      st.crc   <= 16'h0000;
      st.cnt   <= 3'd0;
      st.rcv   <= 16'h0000;
    end else if (proc_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && res.hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proc_fire && res.hit) begin
      crc_valid    <= res.ok;
      computed_crc <= res.computed;
      received_crc <= res.received;
    end
  end

  `P1CRC_ASSERT(a_match_flag, out_valid && crc_valid |-> computed_crc == received_crc, "crc match flag set on differing values")
  `P1CRC_ASSERT(a_crc_cleared, proc_fire && res.hit |=> st.crc == 16'h0000, "crc not cleared after a result")
  `P1CRC_ASSERT(a_digit_count, st.phase == PH_DIGITS |-> st.cnt < DIGITS_PER_CRC, "digit count out of range while collecting")
  `P1CRC_ASSERT(a_byte_held, byte_valid && !proc_fire |=> byte_valid && $stable(byte_q), "pending byte lost")

endmodule

[tb/testbench.sv]
// testbench for the p1 telegram crc checker: random and directed telegram bytes vs a predictor
`timescale 1ns / 1ps

module testbench;
  import p1crc_pkg::*;

  localparam int NUM_ITEMS      = 550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       hold;
  } serial_byte_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] computed;
    logic [15:0] received;
  } crc_report_t;

  typedef logic [7:0] byte_list_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        crc_valid;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;

  serial_byte_t line_bytes[$];
  crc_report_t  expected_reports[$];

  p1crc_phase_t tel_phase = PH_ACCUM;
  logic [15:0]  tel_crc = 16'h0000;
  logic [2:0]   tel_digits = 3'd0;
  logic [15:0]  tel_rcv = 16'h0000;

  int  bytes_sent = 0;
  int  reports_seen = 0;
  int  matches_seen = 0;
  int  err_cnt = 0;
  int  quiet_cycles = 0;
  bit  stuck = 1'b0;
  wire calm = (bytes_sent >= 250) && (bytes_sent < 350);

  p1_telegram_crc_checker_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .crc_valid    (crc_valid),
    .computed_crc (computed_crc),
    .received_crc (received_crc)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic hex_digit(input logic [7:0] b, output logic [3:0] nib);
    logic [7:0] v;
    v = 8'hFF;
    if (b >= "0" && b <= "9") v = b - "0";
    else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
    else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
    nib = v[3:0];
    return v != 8'hFF;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + n;
    return (upper ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] skip_a, input logic [7:0] skip_b);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == skip_a || b == skip_b);
    return b;
  endfunction

  // advance the telegram parser by one byte, queue the report it gives
  task automatic predict_byte(input logic [7:0] b);
    logic [3:0] nib;
    logic       is_hex;
    is_hex = hex_digit(b, nib);
    case (tel_phase)
      PH_DIGITS: begin
        if (is_hex) begin
          tel_rcv = {tel_rcv[11:0], nib};
          tel_digits = tel_digits + 3'd1;
          if (tel_digits >= DIGITS_PER_CRC) begin
            expected_reports.push_back(crc_report_t'{tel_rcv == tel_crc, tel_crc, tel_rcv});
            tel_crc = 16'h0000;
            tel_phase = PH_SKIP;
          end
        end else begin
          expected_reports.push_back(crc_report_t'{1'b0, tel_crc, tel_rcv});
          tel_crc = 16'h0000;
          tel_phase = (b == BYTE_LF) ? PH_ACCUM : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == BYTE_LF) tel_phase = PH_ACCUM;
      end
      default: begin
        tel_phase = PH_ACCUM;
        if (b == BYTE_SLASH) tel_crc = 16'h0000;
        tel_crc = crc16_update(tel_crc, b);
        if (b == BYTE_BANG) begin
          tel_phase = PH_DIGITS;
          tel_digits = 3'd0;
          tel_rcv = 16'h0000;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input bit hold);
    line_bytes.push_back(serial_byte_t'{b, hold});
  endtask

  // letter_case: 0 upper, 1 lower, 2 mixed
  task automatic send_telegram(input byte_list_t body, input int letter_case,
                               input bit corrupt, input bit hold);
    logic [15:0] c;
    logic [15:0] v;
    bit          upper;
    c = crc16_update(16'h0000, BYTE_SLASH);
    push_byte(BYTE_SLASH, hold);
    foreach (body[i]) begin
      c = crc16_update(c, body[i]);
      push_byte(body[i], 1'b0);
    end
    c = crc16_update(c, BYTE_BANG);
    push_byte(BYTE_BANG, 1'b0);
    v = corrupt ? c ^ 16'($urandom_range(65535, 1)) : c;
    for (int k = 3; k >= 0; k--) begin
      upper = (letter_case == 0) || (letter_case == 2 && $urandom_range(1) == 1);
      push_byte(hex_char(v[4*k +: 4], upper), 1'b0);
    end
  endtask

  task automatic push_line_end(input int extra);
    repeat (extra) push_byte(pick_byte(BYTE_LF, BYTE_LF), 1'b0);
    push_byte(BYTE_LF, 1'b0);
  endtask

  // sender: predicts on acceptance, then loads the next byte
  always @(posedge clk) begin : drive_bytes
    serial_byte_t head;
    logic         load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        load = 1'b0;
        if (line_bytes.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          head = line_bytes[0];
          load = !head.hold || expected_reports.size() == 0;
        end
        if (load) begin
          void'(line_bytes.pop_front());
          data_byte <= head.value;
        end
        in_valid <= load;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && $urandom_range(99) < 12;
    end
  end

  always @(posedge clk) begin : check_reports
    crc_report_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (crc_valid) matches_seen++;
        if (expected_reports.size() == 0) begin
          $error("unexpected report: crc_valid %0d computed_crc %h received_crc %h",
                 crc_valid, computed_crc, received_crc);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          if (crc_valid !== want.ok) begin
            $error("crc_valid: expected %0d, got %0d", want.ok, crc_valid);
            err_cnt++;
          end
          if (computed_crc !== want.computed) begin
            $error("computed_crc: expected %h, got %h", want.computed, computed_crc);
            err_cnt++;
          end
          if (received_crc !== want.received) begin
            $error("received_crc: expected %h, got %h", want.received, received_crc);
            err_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) stuck = 1'b1;
      end
    end
  end

  initial begin
    byte_list_t body;
    logic [3:0] nib;
    logic [7:0] term;
    int         r;
    bit         hold_done;
    hold_done = 1'b0;

    // good telegram with byte extremes, slash while skipping
    body = {8'h00, 8'hFF};
    send_telegram(body, 0, 1'b0, 1'b0);
    push_byte(BYTE_SLASH, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    // bang without slash, slash while collecting digits
    push_byte(BYTE_BANG, 1'b0);
    push_byte("1", 1'b0);
    push_byte(BYTE_SLASH, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    // line feed before four digits
    push_byte(BYTE_SLASH, 1'b0);
    push_byte("A", 1'b0);
    push_byte(BYTE_BANG, 1'b0);
    push_byte("a", 1'b0);
    push_byte("B", 1'b0);
    push_byte(BYTE_LF, 1'b0);
    // wrong checksum, empty body, sent after the pipeline drains
    body.delete();
    send_telegram(body, 2, 1'b1, 1'b1);
    push_byte(BYTE_LF, 1'b0);

    while (line_bytes.size() < NUM_ITEMS) begin
      r = $urandom_range(99);
      body.delete();
      if (r < 88) begin
        repeat ($urandom_range(10)) body.push_back(pick_byte(BYTE_SLASH, BYTE_BANG));
      end
      if (r < 75) begin
        send_telegram(body, $urandom_range(2), $urandom_range(3) == 0,
                      !hold_done && line_bytes.size() > 300);
        if (line_bytes.size() > 300) hold_done = 1'b1;
        push_line_end($urandom_range(3));
      end else if (r < 88) begin
        // truncated checksum
        push_byte(BYTE_SLASH, 1'b0);
        foreach (body[i]) push_byte(body[i], 1'b0);
        push_byte(BYTE_BANG, 1'b0);
        repeat ($urandom_range(3)) push_byte(hex_char(4'($urandom_range(15)),
                                                      $urandom_range(1) == 1), 1'b0);
        if ($urandom_range(1) == 0) begin
          push_byte(BYTE_LF, 1'b0);
        end else begin
          do term = 8'($urandom_range(255)); while (hex_digit(term, nib));
          push_byte(term, 1'b0);
          push_line_end($urandom_range(2));
        end
      end else begin
        repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!stuck && !(line_bytes.size() == 0 && !in_valid && expected_reports.size() == 0))
      @(posedge clk);
    if (!stuck) repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d telegram bytes and %0d checksum reports, %0d of them matching",
             bytes_sent, reports_seen, matches_seen);
    if (!stuck && err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[p1_telegram_crc_checker_core.f]
+incdir+hdl
hdl/p1crc_pkg.sv
hdl/p1crc_step.sv
hdl/p1_telegram_crc_checker_core.sv
tb/testbench.sv
